### rtl/core/blal_pkg.sv
package blal_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_CAPACITY   = 32;
	localparam int DEF_WORD_WIDTH = 32;

	// Operation codes carried on the kind port.
	localparam logic [2:0] KIND_APPEND    = 3'd0;
	localparam logic [2:0] KIND_INSERT    = 3'd1;
	localparam logic [2:0] KIND_POP_FIRST = 3'd2;
	localparam logic [2:0] KIND_POP_LAST  = 3'd3;
	localparam logic [2:0] KIND_REMOVE_AT = 3'd4;
	localparam logic [2:0] KIND_READ_AT   = 3'd5;
	localparam logic [2:0] KIND_FIND      = 3'd6;

	// Status codes carried on the status port.
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_FULL      = 3'd1;
	localparam logic [2:0] STAT_EMPTY     = 3'd2;
	localparam logic [2:0] STAT_BAD_POS   = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

	// What every cell does with its stored entry on each clock.
	typedef enum logic [1:0] {
		ENT_HOLD,
		ENT_INSERT,
		ENT_REMOVE
	} blal_entry_op_t;

	// Control broadcast from the sequencer to the row of cells.
	typedef struct packed {
		blal_entry_op_t entry_op;
		logic           capture;
		logic           find_mode;
		logic           shift;
	} blal_ctrl_t;

endpackage

### rtl/core/blal_cell.sv
module blal_cell #(
	parameter int INDEX      = 0,
	parameter int WORD_WIDTH = 32,
	parameter int POS_WIDTH  = 6
) (
	input  logic                    clk,
	input  blal_pkg::blal_ctrl_t    ctrl,
	input  logic [POS_WIDTH-1:0]    pos,
	input  logic [POS_WIDTH-1:0]    count,
	input  logic [WORD_WIDTH-1:0]   word_in,
	input  logic [WORD_WIDTH-1:0]   left_word,
	input  logic [WORD_WIDTH-1:0]   right_word,
	input  logic                    scan_in_hit,
	input  logic [WORD_WIDTH-1:0]   scan_in_word,
	output logic [WORD_WIDTH-1:0]   entry,
	output logic                    scan_hit,
	output logic [WORD_WIDTH-1:0]   scan_word
);
	import blal_pkg::*;

	localparam logic [POS_WIDTH-1:0] MY_IDX   = POS_WIDTH'(INDEX);
	localparam logic [POS_WIDTH-1:0] NEXT_IDX = POS_WIDTH'(INDEX + 1);

	logic [WORD_WIDTH-1:0] entry_q;
	logic                  scan_hit_q;
	logic [WORD_WIDTH-1:0] scan_word_q;
	logic                  match;

	// A find hit needs a live entry; a positional hit only needs the index.
	assign match = ctrl.find_mode ? ((MY_IDX < count) && (entry_q == word_in))
	                              : (MY_IDX == pos);

	always_ff @(posedge clk) begin
		case (ctrl.entry_op)
			ENT_INSERT: begin
				if (MY_IDX == pos) begin
					entry_q <= word_in;
				end else if ((MY_IDX > pos) && (MY_IDX <= count)) begin
					entry_q <= left_word;
				end
			end
			ENT_REMOVE: begin
				if ((MY_IDX >= pos) && (NEXT_IDX < count)) begin
					entry_q <= right_word;
				end
			end
			default: begin
			end
		endcase
	end

	// The scan line samples every cell at once and then drains toward cell zero.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			scan_hit_q  <= match;
			scan_word_q <= entry_q;
		end else if (ctrl.shift) begin
			scan_hit_q  <= scan_in_hit;
			scan_word_q <= scan_in_word;
		end
	end

	assign entry     = entry_q;
	assign scan_hit  = scan_hit_q;
	assign scan_word = scan_word_q;

endmodule

### rtl/core/bounded_array_list_core.sv
// Bounded array list held in a row of cells, one list entry per cell.
// Append, insert, the unused kind and every error found at decode go straight to the result
// register and from there to the output register. Pop, remove, read and find first drain
// the scan line past k cells (the position, or the first match; a find miss drains count - 1).
// A new input beat is taken only once no scan runs and the result register has emptied.
// Reset (arst_n low) empties the list and drops any pending result; entries keep garbage.
module bounded_array_list_core #(
	parameter int CAPACITY   = blal_pkg::DEF_CAPACITY,
	parameter int WORD_WIDTH = blal_pkg::DEF_WORD_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] value,
	input  logic [5:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic [4:0]  found_index,
	output logic [2:0]  status
);
	import blal_pkg::*;

	// The count must hold CAPACITY itself; positions compare at the wider of count and port.
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 6) ? CW : 6;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic                 find_q;
	logic                 res_valid_q;
	logic                 out_valid_q;
	logic [31:0]          res_value_q;
	logic [4:0]           res_index_q;
	logic [2:0]           res_status_q;
	logic [31:0]          out_value_q;
	logic [4:0]           out_index_q;
	logic [2:0]           out_status_q;

	logic                 in_accept;
	logic                 out_take;
	logic                 out_free;
	logic                 res_load;
	logic [PW-1:0]        pos_ext;
	logic [PW-1:0]        count_ext;
	logic [WORD_WIDTH+31:0] value_wide;
	logic [WORD_WIDTH-1:0]  value_word;
	logic [WORD_WIDTH+31:0] scan_wide;
	logic [CW+4:0]        idx_wide;

	// Decode of the accepted item.
	logic                 dec_scan;
	logic                 dec_find;
	logic [2:0]           dec_status;
	blal_entry_op_t       dec_entry_op;
	logic [PW-1:0]        dec_pos;
	logic                 dec_inc;
	logic                 dec_dec;

	// Scan completion.
	logic                 scan_hit0;
	logic                 scan_miss;
	logic                 scan_done;

	blal_ctrl_t           ctrl;

	logic [WORD_WIDTH-1:0] entry_w     [CAPACITY];
	logic [WORD_WIDTH-1:0] left_w      [CAPACITY];
	logic [WORD_WIDTH-1:0] right_w     [CAPACITY];
	logic                  scan_hit_w  [CAPACITY];
	logic [WORD_WIDTH-1:0] scan_word_w [CAPACITY];
	logic                  scan_nhit_w [CAPACITY];
	logic [WORD_WIDTH-1:0] scan_nword_w[CAPACITY];

	// A new item may enter only when no scan runs and the result stage is empty.
	// The output register still holds the previous beat while this one is worked on.
	assign in_stall  = (state_q != ST_IDLE) || res_valid_q;
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || out_take;
	assign res_load  = res_valid_q && out_free;

	assign pos_ext    = PW'(position);
	assign count_ext  = PW'(count_q);
	assign value_wide = {{WORD_WIDTH{1'b0}}, value};
	assign value_word = value_wide[WORD_WIDTH-1:0];

	// Every full, empty and position check is made against the count before the item.
	// Removals reuse the scan line to fetch the word that leaves.
	always_comb begin
		dec_scan     = 1'b0;
		dec_find     = 1'b0;
		dec_status   = STAT_OK;
		dec_entry_op = ENT_HOLD;
		dec_pos      = pos_ext;
		dec_inc      = 1'b0;
		dec_dec      = 1'b0;
		unique case (kind)
			KIND_APPEND: begin
				dec_pos = count_ext;
				if (count_q == CAP_C) begin
					dec_status = STAT_FULL;
				end else begin
					dec_entry_op = ENT_INSERT;
					dec_inc      = 1'b1;
				end
			end
			KIND_INSERT: begin
				if (count_q == CAP_C) begin
					dec_status = STAT_FULL;
				end else if (pos_ext > count_ext) begin
					dec_status = STAT_BAD_POS;
				end else begin
					dec_entry_op = ENT_INSERT;
					dec_inc      = 1'b1;
				end
			end
			KIND_POP_FIRST: begin
				dec_pos = '0;
				if (count_q == '0) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_entry_op = ENT_REMOVE;
					dec_dec      = 1'b1;
					dec_scan     = 1'b1;
				end
			end
			KIND_POP_LAST: begin
				dec_pos = count_ext - PW'(1);
				if (count_q == '0) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_entry_op = ENT_REMOVE;
					dec_dec      = 1'b1;
					dec_scan     = 1'b1;
				end
			end
			KIND_REMOVE_AT: begin
				if (count_q == '0) begin
					dec_status = STAT_EMPTY;
				end else if (pos_ext >= count_ext) begin
					dec_status = STAT_BAD_POS;
				end else begin
					dec_entry_op = ENT_REMOVE;
					dec_dec      = 1'b1;
					dec_scan     = 1'b1;
				end
			end
			KIND_READ_AT: begin
				if (count_q == '0) begin
					dec_status = STAT_EMPTY;
				end else if (pos_ext >= count_ext) begin
					dec_status = STAT_BAD_POS;
				end else begin
					dec_scan = 1'b1;
				end
			end
			KIND_FIND: begin
				dec_find = 1'b1;
				if (count_q == '0) begin
					dec_status = STAT_NOT_FOUND;
				end else begin
					dec_scan = 1'b1;
				end
			end
			default: begin
				// The unused code leaves the list alone and answers all zero.
			end
		endcase
	end

	// The cells see the new operation only in the cycle it is accepted.
	always_comb begin
		ctrl.entry_op  = in_accept ? dec_entry_op : ENT_HOLD;
		ctrl.capture   = in_accept && dec_scan;
		ctrl.find_mode = dec_find;
		ctrl.shift     = (state_q == ST_SCAN) && !scan_done;
	end

	// Cell zero's scan register shows the cell the scan index has reached. Only a
	// find can run out of live entries; a positional fetch always hits.
	assign scan_hit0 = scan_hit_w[0];
	assign scan_miss = find_q && !scan_hit0 && (idx_q == (count_q - CW'(1)));
	assign scan_done = scan_hit0 || scan_miss;
	assign scan_wide = {32'b0, scan_word_w[0]};
	assign idx_wide  = {5'b0, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			find_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (res_load) begin
						res_valid_q <= 1'b0;
					end
					if (in_accept) begin
						if (dec_inc) begin
							count_q <= count_q + CW'(1);
						end else if (dec_dec) begin
							count_q <= count_q - CW'(1);
						end
						idx_q  <= '0;
						find_q <= dec_find;
						if (dec_scan) begin
							state_q <= ST_SCAN;
						end else begin
							res_valid_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result and output payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_accept && !dec_scan) begin
			res_value_q  <= '0;
			res_index_q  <= '0;
			res_status_q <= dec_status;
		end else if ((state_q == ST_SCAN) && scan_done) begin
			if (scan_miss) begin
				res_value_q  <= '0;
				res_index_q  <= '0;
				res_status_q <= STAT_NOT_FOUND;
			end else begin
				res_value_q  <= find_q ? 32'b0 : scan_wide[31:0];
				res_index_q  <= find_q ? idx_wide[4:0] : 5'b0;
				res_status_q <= STAT_OK;
			end
		end
		if (res_load) begin
			out_value_q  <= res_value_q;
			out_index_q  <= res_index_q;
			out_status_q <= res_status_q;
		end
	end

	// Neighbor wiring: the ends of the row see zero.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_nbr
		if (i == 0) begin : g_first
			assign left_w[i] = '0;
		end else begin : g_mid_l
			assign left_w[i] = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w[i]      = '0;
			assign scan_nhit_w[i]  = 1'b0;
			assign scan_nword_w[i] = '0;
		end else begin : g_mid_r
			assign right_w[i]      = entry_w[i+1];
			assign scan_nhit_w[i]  = scan_hit_w[i+1];
			assign scan_nword_w[i] = scan_word_w[i+1];
		end

		blal_cell #(
			.INDEX      (i),
			.WORD_WIDTH (WORD_WIDTH),
			.POS_WIDTH  (PW)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.pos          (dec_pos),
			.count        (count_ext),
			.word_in      (value_word),
			.left_word    (left_w[i]),
			.right_word   (right_w[i]),
			.scan_in_hit  (scan_nhit_w[i]),
			.scan_in_word (scan_nword_w[i]),
			.entry        (entry_w[i]),
			.scan_hit     (scan_hit_w[i]),
			.scan_word    (scan_word_w[i])
		);
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign found_index  = out_index_q;
	assign status       = out_status_q;

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("list count exceeds capacity");

	// An append that fits grows the list by exactly one entry.
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (kind == KIND_APPEND) && (count_q != CAP_C))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not grow the list");

	// A finished result is never dropped while the output register is blocked.
	a_res_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !out_free) |=> res_valid_q)
		else $error("pending result lost");

	// The scan never walks past the live entries; a removal has already lowered the
	// count, so its fetch may sit at the new count.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= count_q))
		else $error("scan index beyond live entries");

	// Any error beat carries a zero word.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != STAT_OK)) |-> (out_value_q == 32'b0))
		else $error("error result carries a word");

endmodule

### bench/bounded_array_list_core_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the bounded array list core.
// A shadow copy of the list is kept in the bench and updated whenever an
// input beat is accepted. The result that the shadow copy gives is queued,
// and every output beat is compared against the oldest queued result.
module bounded_array_list_core_tb;
	import blal_pkg::*;

	localparam int CAP            = DEF_CAPACITY;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_LEN   = 300;
	localparam int DRAIN_CYCLES   = CAP + 8;

	// The kind code that the block ignores.
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	// One result beat as the block returns it.
	typedef struct packed {
		logic [31:0] word;
		logic [4:0]  index;
		logic [2:0]  stat;
	} list_result_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [2:0]  kind         = KIND_APPEND;
	logic [31:0] value        = '0;
	logic [5:0]  position     = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [31:0] result_value;
	logic [4:0]  found_index;
	logic [2:0]  status;

	// Shadow copy of the list contents and its length.
	logic [31:0] shadow_words [CAP];
	int          shadow_len = 0;

	// Results still owed by the block, oldest first.
	list_result_t expected_results [$];

	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_request   = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	bounded_array_list_core #(
		.CAPACITY   (DEF_CAPACITY),
		.WORD_WIDTH (DEF_WORD_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.found_index  (found_index),
		.status       (status)
	);

	always #5 clk = ~clk;

	// Removes the entry at pos from the shadow list, closing the gap, and
	// returns the removed word. The caller makes sure pos is below the length.
	function automatic logic [31:0] take_shadow_entry(input int pos);
		logic [31:0] w;
		w = shadow_words[pos];
		for (int i = pos; i + 1 < shadow_len; i++)
			shadow_words[i] = shadow_words[i + 1];
		shadow_len--;
		return w;
	endfunction

	// Applies one operation to the shadow list and returns the result beat
	// that the block must produce for it. The order of the checks matters:
	// a full list wins over a bad insert position, and an empty list wins
	// over a bad position for remove and read.
	function automatic list_result_t predict_list_op(input logic [2:0] op,
		input logic [31:0] word, input logic [5:0] pos);
		list_result_t r;
		int           p;
		r = '0;
		r.stat = STAT_OK;
		p = int'(pos);
		case (op)
			KIND_APPEND: begin
				if (shadow_len >= CAP) begin
					r.stat = STAT_FULL;
				end else begin
					shadow_words[shadow_len] = word;
					shadow_len++;
				end
			end
			KIND_INSERT: begin
				if (shadow_len >= CAP) begin
					r.stat = STAT_FULL;
				end else if (p > shadow_len) begin
					r.stat = STAT_BAD_POS;
				end else begin
					for (int i = shadow_len; i > p; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[p] = word;
					shadow_len++;
				end
			end
			KIND_POP_FIRST: begin
				if (shadow_len == 0)
					r.stat = STAT_EMPTY;
				else
					r.word = take_shadow_entry(0);
			end
			KIND_POP_LAST: begin
				if (shadow_len == 0)
					r.stat = STAT_EMPTY;
				else
					r.word = take_shadow_entry(shadow_len - 1);
			end
			KIND_REMOVE_AT: begin
				if (shadow_len == 0)
					r.stat = STAT_EMPTY;
				else if (p >= shadow_len)
					r.stat = STAT_BAD_POS;
				else
					r.word = take_shadow_entry(p);
			end
			KIND_READ_AT: begin
				if (shadow_len == 0)
					r.stat = STAT_EMPTY;
				else if (p >= shadow_len)
					r.stat = STAT_BAD_POS;
				else
					r.word = shadow_words[p];
			end
			KIND_FIND: begin
				// Only the first match counts, so later matches are ignored once one is seen.
				r.stat = STAT_NOT_FOUND;
				for (int i = 0; i < shadow_len; i++) begin
					if (r.stat == STAT_NOT_FOUND && shadow_words[i] == word) begin
						r.index = i[4:0];
						r.stat  = STAT_OK;
					end
				end
			end
			default: begin
				// The unused kind leaves the list alone and returns all zero.
			end
		endcase
		return r;
	endfunction

	// Offers one input beat and returns in the time step in which it is
	// accepted. The sender may first sit idle for a random number of cycles.
	// in_stall is read right after the edge, so it is the value that the
	// edge itself saw.
	task automatic offer_op(input logic [2:0] op, input logic [31:0] word,
		input logic [5:0] pos);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		value    <= word;
		position <= pos;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(predict_list_op(op, word, pos));
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Picks a word to search for: mostly one that is in the list, so that
	// finds hit at every depth, and otherwise a random or small word.
	function automatic logic [31:0] pick_search_word();
		if (shadow_len > 0 && $urandom_range(0, 9) < 7)
			return shadow_words[$urandom_range(0, shadow_len - 1)];
		else if ($urandom_range(0, 1) == 0)
			return 32'($urandom_range(0, 3));
		else
			return $urandom;
	endfunction

	// Words to store: a few come from a tiny set so that duplicates appear
	// and find has to report the first of several matches.
	function automatic logic [31:0] pick_store_word();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2, 3:    return 32'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	// Hand-picked beats: every removal, read and find on an empty list, both word
	// extremes, insert at the head and at the tail, positions past the end
	// up to the largest the port carries, a find hit and miss, and the
	// unused kind.
	task automatic test_directed();
		offer_op(KIND_POP_FIRST, 32'h0, 6'd0);
		offer_op(KIND_POP_LAST, 32'h0, 6'd0);
		offer_op(KIND_REMOVE_AT, 32'h0, 6'd0);
		offer_op(KIND_READ_AT, 32'h0, 6'd63);
		offer_op(KIND_FIND, 32'h0, 6'd0);
		offer_op(KIND_APPEND, 32'h0000_0000, 6'd0);
		offer_op(KIND_APPEND, 32'hFFFF_FFFF, 6'd63);
		offer_op(KIND_INSERT, 32'hA5A5_A5A5, 6'd0);
		offer_op(KIND_INSERT, 32'h5A5A_5A5A, 6'd3);
		offer_op(KIND_INSERT, 32'h1234_5678, 6'd63);
		offer_op(KIND_INSERT, 32'h1234_5678, 6'd32);
		offer_op(KIND_READ_AT, 32'h0, 6'd0);
		offer_op(KIND_READ_AT, 32'h0, 6'd3);
		offer_op(KIND_READ_AT, 32'h0, 6'd4);
		offer_op(KIND_FIND, 32'hFFFF_FFFF, 6'd0);
		offer_op(KIND_FIND, 32'h1234_5678, 6'd0);
		offer_op(KIND_REMOVE_AT, 32'h0, 6'd1);
		offer_op(KIND_REMOVE_AT, 32'h0, 6'd32);
		offer_op(KIND_UNUSED, 32'hDEAD_BEEF, 6'd63);
		offer_op(KIND_POP_LAST, 32'h0, 6'd0);
		offer_op(KIND_POP_FIRST, 32'h0, 6'd0);
		offer_op(KIND_FIND, 32'h5A5A_5A5A, 6'd0);
		offer_op(KIND_POP_FIRST, 32'h0, 6'd0);
	endtask

	// Fills the list to capacity, hits it with appends and inserts while
	// full (including an insert whose position is also bad), reads and finds
	// at the last slot, then empties it again from both ends.
	task automatic test_fill_and_drain();
		while (shadow_len < CAP)
			offer_op(KIND_APPEND, $urandom, 6'($urandom_range(0, 63)));
		offer_op(KIND_APPEND, $urandom, 6'd0);
		offer_op(KIND_INSERT, $urandom, 6'd0);
		offer_op(KIND_INSERT, $urandom, 6'd63);
		offer_op(KIND_FIND, shadow_words[CAP - 1], 6'd0);
		offer_op(KIND_READ_AT, 32'h0, 6'(CAP - 1));
		offer_op(KIND_READ_AT, 32'h0, 6'(CAP));
		offer_op(KIND_REMOVE_AT, 32'h0, 6'(CAP - 1));
		offer_op(KIND_INSERT, 32'hC0FF_EE00, 6'(CAP - 1));
		while (shadow_len > 0)
			offer_op(($urandom_range(0, 1) != 0) ? KIND_POP_FIRST : KIND_POP_LAST,
				$urandom, 6'($urandom_range(0, 63)));
	endtask

	// Random operations. The mix swings between a growing and a shrinking
	// mood so that the list keeps travelling between empty and full, which
	// is where the interesting status codes live.
	task automatic test_random_ops(input int n_items);
		bit          growing;
		int          r;
		logic [2:0]  op;
		logic [31:0] w;
		logic [5:0]  pos;
		growing = 1'b1;
		for (int n = 0; n < n_items; n++) begin
			if (shadow_len >= CAP && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (shadow_len == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				growing = ~growing;
			r = $urandom_range(0, 99);
			if (growing) begin
				if (r < 35)      op = KIND_APPEND;
				else if (r < 62) op = KIND_INSERT;
				else if (r < 68) op = KIND_POP_FIRST;
				else if (r < 74) op = KIND_POP_LAST;
				else if (r < 80) op = KIND_REMOVE_AT;
				else if (r < 89) op = KIND_READ_AT;
				else if (r < 98) op = KIND_FIND;
				else             op = KIND_UNUSED;
			end else begin
				if (r < 8)       op = KIND_APPEND;
				else if (r < 14) op = KIND_INSERT;
				else if (r < 32) op = KIND_POP_FIRST;
				else if (r < 50) op = KIND_POP_LAST;
				else if (r < 72) op = KIND_REMOVE_AT;
				else if (r < 85) op = KIND_READ_AT;
				else if (r < 98) op = KIND_FIND;
				else             op = KIND_UNUSED;
			end
			// Positions mostly land on or just past the live range; now and
			// then they cover the whole port.
			if ($urandom_range(0, 9) == 0)
				pos = 6'($urandom_range(0, 63));
			else
				pos = 6'($urandom_range(0, shadow_len));
			w = (op == KIND_FIND) ? pick_search_word() : pick_store_word();
			offer_op(op, w, pos);
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering beats, so the core and its output register fill and the
	// core has to stall its input.
	task automatic test_backpressure(input int n_items);
		set_idling(0, 0);
		hold_request = HOLD_OFF_LEN;
		test_random_ops(n_items);
	endtask

	// Receiver side: check each accepted result beat, then decide whether
	// to stall the next cycle. A long hold-off, once asked for, is counted
	// down here.
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{word: result_value, index: found_index, stat: status};
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h %h %h",
					$time, got.word, got.index, got.stat);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.word !== want.word) begin
					$display("%0t: result_value expected %h actual %h",
						$time, want.word, got.word);
					error_count++;
				end
				if (got.index !== want.index) begin
					$display("%0t: found_index expected %h actual %h",
						$time, want.index, got.index);
					error_count++;
				end
				if (got.stat !== want.stat) begin
					$display("%0t: status expected %h actual %h",
						$time, want.stat, got.stat);
					error_count++;
				end
			end
		end
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog: counts cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();

		// Idling phases: none, sender only, receiver only, both.
		set_idling(0, 0);
		test_random_ops(140);
		set_idling(50, 0);
		test_random_ops(140);
		set_idling(0, 50);
		test_random_ops(140);
		set_idling(36, 36);
		test_random_ops(140);

		test_backpressure(40);
		in_valid <= 1'b0;

		// Let every owed result arrive, then give stray beats a chance to show.
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### bounded_array_list_core.f
rtl/core/blal_pkg.sv
rtl/core/blal_cell.sv
rtl/core/bounded_array_list_core.sv
bench/bounded_array_list_core_tb.sv
